// ===== rtl/stbs_pkg.sv =====
// Shared types and constants for the sorted-table binary search unit.
// No dependencies.
`timescale 1ns / 1ps

package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int DATA_W      = 32;

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_SEARCH = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic wr_en;        // write request payload into the table
    logic start;        // latch key and bounds
    logic probe_first;  // read midpoint of current bounds
    logic probe_next;   // update bounds from compare, read new midpoint
    logic res_ld;       // capture search outcome
    logic res_hit;
    logic out_set;      // present outcome on the result channel
  } ctrl_cmd_t;

  typedef struct packed {
    logic range_empty;
    logic cmp_eq;
    logic next_empty;
    logic out_busy;
  } dp_status_t;

  // floor((lo + hi_excl - 1) / 2); valid only when lo < hi_excl
  function automatic logic [IDX_W-1:0] calc_mid(input logic [CNT_W-1:0] lo,
                                                 input logic [CNT_W-1:0] hi_excl);
    logic [CNT_W:0] s;
    s = {1'b0, lo} + {1'b0, hi_excl} - (CNT_W+1)'(1);
    return s[IDX_W:1];
  endfunction

endpackage

// ===== rtl/sorted_table_binary_search_unit.sv =====
// Top level of the sorted-table binary search unit.
// Depends on stbs_pkg, stbs_ctrl, stbs_dp (which holds stbs_ram).
`timescale 1ns / 1ps

// A load request (func 0) writes one table entry; it gives no result. A
// search request (func 1) probes the table one entry per cycle, bounded
// by the single read port of the table RAM: with n entries in use it
// takes up to floor(log2(n)) + 1 probes plus the setup and hand-off
// states (start, finish), and no probe at all when no entries are in use.
// One request is in flight at a time; a finished result waits in the
// output register, and a new request is taken while it waits.
// cfg_wr_data sets the number of entries in use (values above 1024 act
// as 1024); write it only while the unit is idle.

module sorted_table_binary_search_unit import stbs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_func,
  input  logic [IDX_W-1:0]         in_entry_index,
  input  logic signed [DATA_W-1:0] in_data_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_found,
  input  logic                     cfg_wr_en,
  input  logic [CNT_W-1:0]         cfg_wr_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_func  (in_func),
    .status   (status),
    .cmd      (cmd)
  );

  stbs_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_entry_index (in_entry_index),
    .in_data_value  (in_data_value),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found)
  );

endmodule

// ===== rtl/stbs_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/stbs_ctrl.sv =====
// Controller state machine for the binary search unit.
// Depends on stbs_pkg.
`timescale 1ns / 1ps

module stbs_ctrl import stbs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_func,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          if (in_func == FUNC_SEARCH) begin
            cmd.start = 1'b1;
            state_nxt = ST_START;
          end else begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      ST_START: begin
        if (status.range_empty) begin
          cmd.res_ld = 1'b1;
          state_nxt  = ST_FINISH;
        end else begin
          cmd.probe_first = 1'b1;
          state_nxt       = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (status.cmp_eq) begin
          cmd.res_ld  = 1'b1;
          cmd.res_hit = 1'b1;
          state_nxt   = ST_FINISH;
        end else if (status.next_empty) begin
          cmd.res_ld = 1'b1;
          state_nxt  = ST_FINISH;
        end else begin
          cmd.probe_next = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!status.out_busy) begin
          cmd.out_set = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/stbs_dp.sv =====
// Datapath for the binary search unit: table RAM, bounds, key, count
// register and result register. Depends on stbs_pkg and stbs_ram.
`timescale 1ns / 1ps

module stbs_dp import stbs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctrl_cmd_t                cmd,
  output dp_status_t               status,
  input  logic [IDX_W-1:0]         in_entry_index,
  input  logic signed [DATA_W-1:0] in_data_value,
  input  logic                     cfg_wr_en,
  input  logic [CNT_W-1:0]         cfg_wr_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_found
);

  logic [CNT_W-1:0]         count_r;
  logic signed [DATA_W-1:0] key_r;
  logic [CNT_W-1:0]         low_r, hi_r;
  logic [IDX_W-1:0]         mid_r;
  logic                     res_r;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_found_r;

  logic [CNT_W-1:0]         count_sat;
  logic [CNT_W-1:0]         low_nxt, hi_nxt;
  logic [IDX_W-1:0]         rd_addr;
  logic                     rd_en;
  logic signed [DATA_W-1:0] probe;
  logic                     key_gt;

  assign count_sat = (count_r > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : count_r;

  assign key_gt  = key_r > probe;
  assign low_nxt = key_gt ? ({1'b0, mid_r} + CNT_W'(1)) : low_r;
  assign hi_nxt  = key_gt ? hi_r : {1'b0, mid_r};

  assign rd_en   = cmd.probe_first | cmd.probe_next;
  assign rd_addr = cmd.probe_first ? calc_mid(low_r, hi_r) : calc_mid(low_nxt, hi_nxt);

  stbs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (in_entry_index),
    .wr_data (in_data_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (probe)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_wr_en) begin
      count_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r <= in_data_value;
      low_r <= '0;
      hi_r  <= count_sat;
    end else if (cmd.probe_next) begin
      low_r <= low_nxt;
      hi_r  <= hi_nxt;
    end
    if (rd_en) begin
      mid_r <= rd_addr;
    end
    if (cmd.res_ld) begin
      res_r <= cmd.res_hit;
    end
    if (cmd.out_set) begin
      out_found_r <= res_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_set) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign status.range_empty = low_r >= hi_r;
  assign status.cmp_eq      = key_r == probe;
  assign status.next_empty  = low_nxt >= hi_nxt;
  assign status.out_busy    = out_valid_r & ~out_ready;

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;

endmodule
